// ----- rtl/delimiter_record_splitter_unit_defines.svh -----
// Assertion macros shared by the delimiter record splitter RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef DELIMITER_RECORD_SPLITTER_UNIT_DEFINES_SVH
`define DELIMITER_RECORD_SPLITTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DRS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/drs_pkg.sv -----
// Shared types and constants for the delimiter record splitter.
// No dependencies; imported by every RTL module of the block.
package drs_pkg;

  localparam int BYTE_W          = 8;
  localparam int PAT_W           = 64;
  localparam int PLEN_W          = 4;
  localparam int PADDR_W         = 4;
  localparam int PDATA_W         = 64;
  localparam int MAX_PATTERN_DEF = 8;

  localparam logic [PAT_W-1:0]  PATTERN_BYTES_RST  = 64'h0000_0000_0000_0A0D;
  localparam logic [PLEN_W-1:0] PATTERN_LENGTH_RST = 4'd2;

  // Register select, taken from paddr bit 3 (8-byte register spacing).
  localparam logic SEL_PATTERN_BYTES  = 1'b0;
  localparam logic SEL_PATTERN_LENGTH = 1'b1;

  typedef struct packed {
    logic              emit;
    logic              is_end;
    logic [BYTE_W-1:0] data;
  } step_result_t;

endpackage

// ----- rtl/drs_window.sv -----
// Held-byte window and delimiter compare for the record splitter.
// Depends on drs_pkg and the assertion macro header.
`include "delimiter_record_splitter_unit_defines.svh"

module drs_window import drs_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step_en,
  input  logic               clear,
  input  logic [BYTE_W-1:0]  data_byte,
  input  logic [PAT_W-1:0]   pattern_bytes,
  input  logic [PLEN_W-1:0]  pattern_length,
  output step_result_t       res
);

  localparam int CW = $clog2(MAX_PATTERN + 1);

  logic [BYTE_W-1:0] held [MAX_PATTERN];
  logic [BYTE_W-1:0] held_next [MAX_PATTERN];
  logic [BYTE_W-1:0] win [MAX_PATTERN];
  logic [CW-1:0]     held_count;
  logic [CW-1:0]     held_count_next;
  logic [CW-1:0]     len;
  logic              fill;
  logic              mismatch;

  always_comb begin
    if (pattern_length == '0) begin
      len = CW'(1);
    end else if (pattern_length > PLEN_W'(MAX_PATTERN)) begin
      len = CW'(MAX_PATTERN);
    end else begin
      len = CW'(pattern_length);
    end
  end

  always_comb begin
    fill     = (held_count + CW'(1)) < len;
    mismatch = 1'b0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (CW'(i) < held_count) begin
        win[i] = held[i];
      end else if (CW'(i) == held_count) begin
        win[i] = data_byte;
      end else begin
        win[i] = '0;
      end
      if ((CW'(i) < len) && (win[i] != pattern_bytes[i*BYTE_W +: BYTE_W])) begin
        mismatch = 1'b1;
      end
    end

    for (int i = 0; i < MAX_PATTERN; i++) begin
      held_next[i] = held[i];
    end
    if (fill) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        if (CW'(i) == held_count) begin
          held_next[i] = data_byte;
        end
      end
      held_count_next = held_count + CW'(1);
    end else if (!mismatch) begin
      held_count_next = '0;
    end else begin
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
        held_next[i] = win[i+1];
      end
      held_count_next = len - CW'(1);
    end

    res.emit   = !fill;
    res.is_end = !fill && !mismatch;
    res.data   = (!fill && mismatch) ? win[0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      held_count <= '0;
    end else if (step_en) begin
      held_count <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        held[i] <= held_next[i];
      end
    end
  end

  `DRS_ASSERT_NOW(a_held_below_len, clk, rst, 1'b1, held_count < len,
    "held count reached delimiter length")
  `DRS_ASSERT_NOW(a_fill_no_word, clk, rst, step_en && ((held_count + CW'(1)) < len),
    !res.emit, "word produced while window still filling")
  `DRS_ASSERT_NEXT(a_end_drops_window, clk, rst, step_en && res.is_end,
    held_count == '0, "window not dropped after record end")

endmodule

// ----- rtl/delimiter_record_splitter_unit.sv -----
// Delimiter record splitter top level: config registers and result register.
// Depends on drs_pkg, drs_window and the assertion macro header.
//
// Input channel data_valid/data_ready carries one stream byte per word
// (data_byte, chunk_end; chunk_end does not affect splitting). Output channel
// rec_valid/rec_ready carries one record word: a data byte in out_byte, or a
// record end with is_record_end high and out_byte zero.
// An input word gives zero or one record words. A word is accepted in each
// cycle that data_ready is high; its result is in the output register in the
// cycle after acceptance. Throughput is one byte per cycle while data_ready
// is high, with a combinational compare of held bytes against the delimiter.
// While the receiver stalls with a result waiting, data_ready drops; it
// rises again in the cycle rec_ready is high.
// APB port: pattern_bytes at 0x0, pattern_length at 0x8. Reset loads CRLF,
// length 2, clears the held window and empties the output register.
// Writing pattern_length discards held bytes. Bytes still held at stream
// end stay until pushed out by later bytes.
`include "delimiter_record_splitter_unit_defines.svh"

module delimiter_record_splitter_unit import drs_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               data_valid,
  output logic               data_ready,
  input  logic [BYTE_W-1:0]  data_byte,
  input  logic               chunk_end,
  output logic               rec_valid,
  input  logic               rec_ready,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               is_record_end
);

  logic [PAT_W-1:0]  pattern_bytes;
  logic [PLEN_W-1:0] pattern_length;
  logic              cfg_wr;
  logic              len_wr;
  logic              data_accept;
  step_result_t      step;

  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign len_wr      = cfg_wr && (paddr[3] == SEL_PATTERN_LENGTH);
  assign data_ready  = !rec_valid || rec_ready;
  assign data_accept = data_valid && data_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= PATTERN_BYTES_RST;
      pattern_length <= PATTERN_LENGTH_RST;
    end else if (cfg_wr) begin
      case (paddr[3])
        SEL_PATTERN_BYTES:  pattern_bytes  <= pwdata;
        SEL_PATTERN_LENGTH: pattern_length <= pwdata[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      SEL_PATTERN_BYTES:  prdata = pattern_bytes;
      SEL_PATTERN_LENGTH: prdata = PDATA_W'(pattern_length);
      default:            prdata = '0;
    endcase
  end

  drs_window #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_window (
    .clk            (clk),
    .rst            (rst),
    .step_en        (data_accept),
    .clear          (len_wr),
    .data_byte      (data_byte),
    .pattern_bytes  (pattern_bytes),
    .pattern_length (pattern_length),
    .res            (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (data_accept) begin
      rec_valid <= step.emit;
    end else if (rec_ready) begin
      rec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_accept && step.emit) begin
      out_byte      <= step.data;
      is_record_end <= step.is_end;
    end
  end

  `DRS_ASSERT_NEXT(a_emit_shows, clk, rst, data_accept && step.emit, rec_valid,
    "produced word missing from output register")
  `DRS_ASSERT_NOW(a_end_zero_byte, clk, rst, rec_valid && is_record_end,
    out_byte == '0, "record end carries a data byte")
  `DRS_ASSERT_NEXT(a_stall_holds, clk, rst, rec_valid && !rec_ready,
    rec_valid && $stable(out_byte) && $stable(is_record_end), "stalled word changed")

endmodule
